>>> hw/rtl/ctls_pkg.sv
// ============================================================================
// ctls_pkg
// Shared types, token codes and lookup functions for the source tokenizer.
// ============================================================================
package ctls_pkg;

    // Default values of the top-level parameters.
    localparam int DEF_MAX_NAME_LEN   = 63;
    localparam int DEF_MAX_INT_DIGITS = 61;
    localparam int DEF_MAX_STRING_LEN = 255;
    localparam int DEF_OFFSET_BITS    = 24;

    // Output queue geometry.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = 3;
    localparam int FIFO_CNT_W = 4;

    localparam logic [62:0] VAL_MAX = {63{1'b1}};

    // Token kinds.
    localparam logic [5:0] K_INT     = 6'd0;
    localparam logic [5:0] K_FLOAT   = 6'd1;
    localparam logic [5:0] K_STRING  = 6'd2;
    localparam logic [5:0] K_IDENT   = 6'd3;
    localparam logic [5:0] K_IF      = 6'd4;
    localparam logic [5:0] K_ELSE    = 6'd5;
    localparam logic [5:0] K_WHILE   = 6'd6;
    localparam logic [5:0] K_FOR     = 6'd7;
    localparam logic [5:0] K_RETURN  = 6'd8;
    localparam logic [5:0] K_KWINT   = 6'd9;
    localparam logic [5:0] K_KWFLOAT = 6'd10;
    localparam logic [5:0] K_VOID    = 6'd11;
    localparam logic [5:0] K_PLUS    = 6'd12;
    localparam logic [5:0] K_MINUS   = 6'd13;
    localparam logic [5:0] K_STAR    = 6'd14;
    localparam logic [5:0] K_SLASH   = 6'd15;
    localparam logic [5:0] K_PERCENT = 6'd16;
    localparam logic [5:0] K_EQEQ    = 6'd17;
    localparam logic [5:0] K_NE      = 6'd18;
    localparam logic [5:0] K_LT      = 6'd19;
    localparam logic [5:0] K_GT      = 6'd20;
    localparam logic [5:0] K_LE      = 6'd21;
    localparam logic [5:0] K_GE      = 6'd22;
    localparam logic [5:0] K_ASSIGN  = 6'd23;
    localparam logic [5:0] K_ANDAND  = 6'd24;
    localparam logic [5:0] K_OROR    = 6'd25;
    localparam logic [5:0] K_NOT     = 6'd26;
    localparam logic [5:0] K_LPAREN  = 6'd27;
    localparam logic [5:0] K_RPAREN  = 6'd28;
    localparam logic [5:0] K_LBRACE  = 6'd29;
    localparam logic [5:0] K_RBRACE  = 6'd30;
    localparam logic [5:0] K_LBRACK  = 6'd31;
    localparam logic [5:0] K_RBRACK  = 6'd32;
    localparam logic [5:0] K_SEMI    = 6'd33;
    localparam logic [5:0] K_COLON   = 6'd34;
    localparam logic [5:0] K_COMMA   = 6'd35;
    localparam logic [5:0] K_DOT     = 6'd36;
    localparam logic [5:0] K_ARROW   = 6'd37;
    localparam logic [5:0] K_EOF     = 6'd38;
    localparam logic [5:0] K_ERR     = 6'd39;

    // Error causes.
    localparam logic CAUSE_UNTERM  = 1'b0;
    localparam logic CAUSE_UNKNOWN = 1'b1;

    // Scanner modes.
    typedef enum logic [9:0] {
        M_IDLE  = 10'b0000000001,
        M_IDENT = 10'b0000000010,
        M_INT   = 10'b0000000100,
        M_DOT   = 10'b0000001000,
        M_FRAC  = 10'b0000010000,
        M_STR   = 10'b0000100000,
        M_OP    = 10'b0001000000,
        M_LCMT  = 10'b0010000000,
        M_BCMT  = 10'b0100000000,
        M_BSTAR = 10'b1000000000
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       end_of_source;
    } src_word_t;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic        error_cause;
        logic [15:0] start_line;
        logic [15:0] start_column;
        logic [23:0] start_offset;
        logic [8:0]  token_length;
        logic [62:0] int_value;
        logic        last_of_run;
    } tok_word_t;

    // Up to three words pushed into the output queue per accepted byte.
    typedef struct packed {
        logic [1:0]         count;
        tok_word_t [2:0]    words;
    } tok_push_t;

    function automatic logic [5:0] single_kind(logic [7:0] c);
        logic [5:0] k;
        unique case (c)
            "+":     k = K_PLUS;
            "-":     k = K_MINUS;
            "*":     k = K_STAR;
            "/":     k = K_SLASH;
            "%":     k = K_PERCENT;
            "=":     k = K_ASSIGN;
            "<":     k = K_LT;
            ">":     k = K_GT;
            "!":     k = K_NOT;
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            "{":     k = K_LBRACE;
            "}":     k = K_RBRACE;
            "[":     k = K_LBRACK;
            "]":     k = K_RBRACK;
            ";":     k = K_SEMI;
            ":":     k = K_COLON;
            ",":     k = K_COMMA;
            ".":     k = K_DOT;
            default: k = K_ERR;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] dual_kind(logic [7:0] a, logic [7:0] b);
        logic [5:0] k;
        k = K_ERR;
        if (a == "=" && b == "=") k = K_EQEQ;
        if (a == "!" && b == "=") k = K_NE;
        if (a == "<" && b == "=") k = K_LE;
        if (a == ">" && b == "=") k = K_GE;
        if (a == "&" && b == "&") k = K_ANDAND;
        if (a == "|" && b == "|") k = K_OROR;
        if (a == "-" && b == ">") k = K_ARROW;
        return k;
    endfunction

    // Keyword match on the first six bytes (first byte lowest) and length.
    function automatic logic [5:0] kw_kind(logic [2:0] len, logic [47:0] p);
        logic [5:0] k;
        k = K_IDENT;
        if (len == 3'd2 && p == 48'h0000_0000_6669) k = K_IF;
        if (len == 3'd4 && p == 48'h0000_6573_6C65) k = K_ELSE;
        if (len == 3'd5 && p == 48'h0065_6C69_6877) k = K_WHILE;
        if (len == 3'd3 && p == 48'h0000_0072_6F66) k = K_FOR;
        if (len == 3'd6 && p == 48'h6E72_7574_6572) k = K_RETURN;
        if (len == 3'd3 && p == 48'h0000_0074_6E69) k = K_KWINT;
        if (len == 3'd5 && p == 48'h0074_616F_6C66) k = K_KWFLOAT;
        if (len == 3'd4 && p == 48'h0000_6469_6F76) k = K_VOID;
        return k;
    endfunction

    function automatic logic [15:0] sat16(logic [15:0] v, logic [15:0] n);
        logic [16:0] s;
        s = {1'b0, v} + {1'b0, n};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

endpackage

>>> hw/rtl/c_like_source_tokenizer.sv
// ============================================================================
// c_like_source_tokenizer
// Streaming tokenizer for a small C-like language: one source byte in per
// word, token records out.
// ============================================================================
//  channel | valid     | stall     | payload
//  src     | src_valid | src_stall | src_word (source_byte, end_of_source)
//  tok     | tok_valid | tok_stall | tok_word (one token record)
//
//  A byte is taken per cycle unless stalled; its tokens enter an eight-word
//  output queue in the same cycle and leave it one per cycle unless stalled.
//  src_stall rises while the queue has fewer than three free words.
//  After reset the block is ready at once; line and column start at 1.
//  After EOF or an error the block keeps taking bytes but emits nothing.
// ============================================================================
module c_like_source_tokenizer #(
    parameter int MAX_NAME_LEN   = ctls_pkg::DEF_MAX_NAME_LEN,
    parameter int MAX_INT_DIGITS = ctls_pkg::DEF_MAX_INT_DIGITS,
    parameter int MAX_STRING_LEN = ctls_pkg::DEF_MAX_STRING_LEN,
    parameter int OFFSET_BITS    = ctls_pkg::DEF_OFFSET_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_stall,
    input  ctls_pkg::src_word_t src_word,
    output logic                tok_valid,
    input  logic                tok_stall,
    output ctls_pkg::tok_word_t tok_word
);
    import ctls_pkg::*;

    tok_push_t push;
    logic      room;
    logic      step;
    logic      halted;

    assign src_stall = !room;
    assign step      = src_valid && room;

    ctls_core #(
        .MAX_NAME_LEN   (MAX_NAME_LEN),
        .MAX_INT_DIGITS (MAX_INT_DIGITS),
        .MAX_STRING_LEN (MAX_STRING_LEN),
        .OFFSET_BITS    (OFFSET_BITS)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .src_word (src_word),
        .push     (push),
        .halted   (halted)
    );

    ctls_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_word  (tok_word)
    );

    // Words are pushed only for an accepted byte.
    a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> (src_valid && !src_stall && !halted))
        else $error("push without accepted byte");

endmodule

>>> hw/rtl/ctls_core.sv
// ============================================================================
// ctls_core
// Scanner state and the single-pass logic that turns one byte into up to
// three token words.
// ============================================================================
module ctls_core #(
    parameter int MAX_NAME_LEN   = ctls_pkg::DEF_MAX_NAME_LEN,
    parameter int MAX_INT_DIGITS = ctls_pkg::DEF_MAX_INT_DIGITS,
    parameter int MAX_STRING_LEN = ctls_pkg::DEF_MAX_STRING_LEN,
    parameter int OFFSET_BITS    = ctls_pkg::DEF_OFFSET_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  ctls_pkg::src_word_t src_word,
    output ctls_pkg::tok_push_t push,
    output logic                halted
);
    import ctls_pkg::*;

    localparam int DEC_CAP = MAX_INT_DIGITS + 2;
    localparam int CNT_W   = $clog2(2 * MAX_STRING_LEN + MAX_NAME_LEN + DEC_CAP + 4);
    localparam int SC_W    = $clog2(MAX_STRING_LEN + 2);

    scan_mode_t             mode_reg, mode_next;
    logic [7:0]             held_reg, held_next;
    logic [15:0]            line_reg, line_next, col_reg, col_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic [15:0]            sline_reg, sline_next, scol_reg, scol_next;
    logic [OFFSET_BITS-1:0] soff_reg, soff_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [62:0]            acc_reg, acc_next;
    logic [47:0]            prefix_reg, prefix_next;
    logic                   esc_reg, esc_next;
    logic                   halt_reg, halt_next;
    logic [SC_W-1:0]        sc_reg, sc_next;

    logic [7:0]  c;
    logic        at_end;
    logic        is_name;
    logic [66:0] acc_mul;
    logic [2:0]  kw_len;
    logic [5:0]  ident_kind;
    logic [8:0]  len_sat;
    logic [23:0] soff24, coff24, doff24;
    logic [15:0] dcol;
    logic [OFFSET_BITS-1:0] doff;
    logic [5:0]  held_single_kind;
    logic [5:0]  pair_kind;

    // Dispatch of a byte from the idle mode.
    scan_mode_t  d_mode;
    logic        d_emit;
    logic [5:0]  d_kind;

    logic [1:0]  n;
    tok_word_t [2:0] tk;

    function automatic tok_word_t mk(logic [5:0] kind, logic cause, logic [15:0] ln,
                                     logic [15:0] cl, logic [23:0] of, logic [8:0] len,
                                     logic [62:0] val);
        tok_word_t w;
        w.token_kind   = kind;
        w.error_cause  = cause;
        w.start_line   = ln;
        w.start_column = cl;
        w.start_offset = of;
        w.token_length = len;
        w.int_value    = val;
        w.last_of_run  = 1'b0;
        return w;
    endfunction

    // Byte decode and shared helper values.
    always_comb
    begin
        logic [31:0] cnt32;
        c       = src_word.source_byte;
        at_end  = src_word.end_of_source || (c == 8'd0);
        is_name = is_alpha(c) || is_digit(c) || c == "_";
        acc_mul = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + 67'(c[3:0]);
        kw_len  = (cnt_reg < CNT_W'(7)) ? cnt_reg[2:0] : 3'd7;
        ident_kind = kw_kind(kw_len, prefix_reg);
        cnt32   = 32'(cnt_reg);
        len_sat = (cnt32 > 32'd511) ? 9'd511 : cnt32[8:0];
        soff24  = 24'(32'(soff_reg));
        coff24  = 24'(32'(off_reg));
        dcol    = sat16(scol_reg, 16'(cnt32));
        doff    = soff_reg + OFFSET_BITS'(cnt32);
        doff24  = 24'(32'(doff));
        held_single_kind = single_kind(held_reg);
        pair_kind        = dual_kind(held_reg, c);
    end

    // What a byte does when it starts a new token.
    always_comb
    begin
        d_emit = 1'b0;
        d_kind = single_kind(c);
        if (is_space(c))
            d_mode = M_IDLE;
        else if (is_digit(c))
            d_mode = M_INT;
        else if (is_alpha(c) || c == "_")
            d_mode = M_IDENT;
        else if (c == 8'h22)
            d_mode = M_STR;
        else if (c == "=" || c == "!" || c == "<" || c == ">" || c == "&" || c == "|"
                 || c == "-" || c == "/")
            d_mode = M_OP;
        else
        begin
            d_mode = M_IDLE;
            d_emit = 1'b1;
        end
    end

    // Next state and emitted words.
    always_comb
    begin
        logic do_disp;
        do_disp     = 1'b0;
        n           = 2'd0;
        tk          = '0;
        mode_next   = mode_reg;
        held_next   = held_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        off_next    = off_reg;
        sline_next  = sline_reg;
        scol_next   = scol_reg;
        soff_next   = soff_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        prefix_next = prefix_reg;
        esc_next    = esc_reg;
        halt_next   = halt_reg;
        sc_next     = sc_reg;

        if (!halt_reg && at_end)
        begin
            unique case (mode_reg)
                M_IDENT:
                begin
                    tk[n] = mk(ident_kind, 1'b0, sline_reg, scol_reg, soff24, len_sat, '0);
                    n = n + 2'd1;
                end
                M_INT:
                begin
                    tk[n] = mk(K_INT, 1'b0, sline_reg, scol_reg, soff24, len_sat, acc_reg);
                    n = n + 2'd1;
                end
                M_DOT:
                begin
                    tk[n] = mk(K_INT, 1'b0, sline_reg, scol_reg, soff24, len_sat, acc_reg);
                    n = n + 2'd1;
                    tk[n] = mk(K_DOT, 1'b0, sline_reg, dcol, doff24, 9'd1, '0);
                    n = n + 2'd1;
                end
                M_FRAC:
                begin
                    tk[n] = mk(K_FLOAT, 1'b0, sline_reg, scol_reg, soff24, len_sat, '0);
                    n = n + 2'd1;
                end
                M_STR:
                begin
                    tk[n] = mk(K_ERR, CAUSE_UNTERM, sline_reg, scol_reg, soff24, len_sat, '0);
                    n = n + 2'd1;
                end
                M_OP:
                begin
                    if (held_single_kind == K_ERR)
                        tk[n] = mk(K_ERR, CAUSE_UNKNOWN, sline_reg, scol_reg, soff24, 9'd1,
                                   '0);
                    else
                        tk[n] = mk(held_single_kind, 1'b0, sline_reg, scol_reg, soff24, 9'd1,
                                   '0);
                    n = n + 2'd1;
                end
                default:
                begin
                end
            endcase
            // An end inside a string or after a bad operator byte gives no EOF.
            if (!(mode_reg == M_STR || (mode_reg == M_OP && held_single_kind == K_ERR)))
            begin
                tk[n] = mk(K_EOF, 1'b0, line_reg, col_reg, coff24, 9'd0, '0);
                n = n + 2'd1;
            end
            halt_next = 1'b1;
            mode_next = M_IDLE;
        end
        else if (!halt_reg)
        begin
            unique case (mode_reg)
                M_IDLE:
                    do_disp = 1'b1;
                M_IDENT:
                begin
                    if (is_name && cnt_reg < MAX_NAME_LEN)
                    begin
                        if (cnt_reg < CNT_W'(6))
                            prefix_next = prefix_reg | (48'(c) << {cnt_reg[2:0], 3'b000});
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        tk[n] = mk(ident_kind, 1'b0, sline_reg, scol_reg, soff24, len_sat, '0);
                        n = n + 2'd1;
                        do_disp = 1'b1;
                    end
                end
                M_INT:
                begin
                    if (is_digit(c) && cnt_reg < MAX_INT_DIGITS)
                    begin
                        acc_next = (acc_mul > 67'(VAL_MAX)) ? VAL_MAX : acc_mul[62:0];
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else if (c == ".")
                        mode_next = M_DOT;
                    else
                    begin
                        tk[n] = mk(K_INT, 1'b0, sline_reg, scol_reg, soff24, len_sat, acc_reg);
                        n = n + 2'd1;
                        do_disp = 1'b1;
                    end
                end
                M_DOT:
                begin
                    if (is_digit(c))
                    begin
                        mode_next = M_FRAC;
                        cnt_next  = cnt_reg + CNT_W'(2);
                    end
                    else
                    begin
                        tk[n] = mk(K_INT, 1'b0, sline_reg, scol_reg, soff24, len_sat, acc_reg);
                        n = n + 2'd1;
                        tk[n] = mk(K_DOT, 1'b0, sline_reg, dcol, doff24, 9'd1, '0);
                        n = n + 2'd1;
                        do_disp = 1'b1;
                    end
                end
                M_FRAC:
                begin
                    if (is_digit(c) && cnt_reg < DEC_CAP)
                        cnt_next = cnt_reg + 1'b1;
                    else
                    begin
                        tk[n] = mk(K_FLOAT, 1'b0, sline_reg, scol_reg, soff24, len_sat, '0);
                        n = n + 2'd1;
                        do_disp = 1'b1;
                    end
                end
                M_STR:
                begin
                    if (esc_reg)
                    begin
                        esc_next = 1'b0;
                        sc_next  = sc_reg + 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else if (c == 8'h22)
                    begin
                        tk[n] = mk(K_STRING, 1'b0, sline_reg, scol_reg, soff24, len_sat, '0);
                        n = n + 2'd1;
                        mode_next = M_IDLE;
                    end
                    else if (sc_reg >= MAX_STRING_LEN)
                    begin
                        tk[n] = mk(K_ERR, CAUSE_UNTERM, sline_reg, scol_reg, soff24, len_sat,
                                   '0);
                        n = n + 2'd1;
                        halt_next = 1'b1;
                        mode_next = M_IDLE;
                    end
                    else if (c == 8'h5C)
                    begin
                        esc_next = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        sc_next  = sc_reg + 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                M_OP:
                begin
                    if (held_reg == "/" && c == "/")
                        mode_next = M_LCMT;
                    else if (held_reg == "/" && c == "*")
                        mode_next = M_BCMT;
                    else if (pair_kind != K_ERR)
                    begin
                        tk[n] = mk(pair_kind, 1'b0, sline_reg, scol_reg, soff24, 9'd2, '0);
                        n = n + 2'd1;
                        mode_next = M_IDLE;
                    end
                    else if (held_single_kind == K_ERR)
                    begin
                        tk[n] = mk(K_ERR, CAUSE_UNKNOWN, sline_reg, scol_reg, soff24, 9'd1,
                                   '0);
                        n = n + 2'd1;
                        halt_next = 1'b1;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        tk[n] = mk(held_single_kind, 1'b0, sline_reg, scol_reg, soff24, 9'd1,
                                   '0);
                        n = n + 2'd1;
                        do_disp = 1'b1;
                    end
                end
                M_LCMT:
                    if (c == 8'h0A)
                        mode_next = M_IDLE;
                M_BCMT:
                    if (c == "*")
                        mode_next = M_BSTAR;
                M_BSTAR:
                begin
                    if (c == "/")
                        mode_next = M_IDLE;
                    else if (c != "*")
                        mode_next = M_BCMT;
                end
                default:
                    mode_next = M_IDLE;
            endcase

            // Start a new token from this byte.
            if (do_disp)
            begin
                mode_next   = d_mode;
                sline_next  = line_reg;
                scol_next   = col_reg;
                soff_next   = off_reg;
                cnt_next    = (c == 8'h22) ? '0 : CNT_W'(1);
                acc_next    = 63'(c[3:0]);
                prefix_next = 48'(c);
                held_next   = c;
                sc_next     = '0;
                esc_next    = 1'b0;
                // A name byte after an over-long identifier stays a name.
                if (mode_reg == M_IDENT && is_name)
                    mode_next = M_IDENT;
                else if (d_emit)
                begin
                    if (d_kind == K_ERR)
                    begin
                        tk[n] = mk(K_ERR, CAUSE_UNKNOWN, line_reg, col_reg, coff24, 9'd1, '0);
                        halt_next = 1'b1;
                    end
                    else
                        tk[n] = mk(d_kind, 1'b0, line_reg, col_reg, coff24, 9'd1, '0);
                    n = n + 2'd1;
                end
            end

            // Advance the source position.
            if (c == 8'h0A)
            begin
                line_next = sat16(line_reg, 16'd1);
                col_next  = 16'd1;
            end
            else
                col_next = sat16(col_reg, 16'd1);
            off_next = off_reg + 1'b1;
        end

        if (n != 2'd0)
            tk[n - 2'd1].last_of_run = 1'b1;
    end

    assign push.count = step ? n : 2'd0;
    assign push.words = tk;
    assign halted     = halt_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            halt_reg <= 1'b0;
            esc_reg  <= 1'b0;
            line_reg <= 16'd1;
            col_reg  <= 16'd1;
            off_reg  <= '0;
            cnt_reg  <= '0;
            sc_reg   <= '0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            halt_reg <= halt_next;
            esc_reg  <= esc_next;
            line_reg <= line_next;
            col_reg  <= col_next;
            off_reg  <= off_next;
            cnt_reg  <= cnt_next;
            sc_reg   <= sc_next;
        end
    end

    // Token payload state.
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            held_reg   <= held_next;
            sline_reg  <= sline_next;
            scol_reg   <= scol_next;
            soff_reg   <= soff_next;
            acc_reg    <= acc_next;
            prefix_reg <= prefix_next;
        end
    end

    // Nothing comes out once the scanner has stopped.
    a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |-> push.count == 2'd0)
        else $error("token emitted after halt");

    // Halt is never released without reset.
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg)
        else $error("halt released");

    // The string character count never runs past its bound.
    a_str_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sc_reg <= SC_W'(MAX_STRING_LEN))
        else $error("string character count overflow");

endmodule

>>> hw/rtl/ctls_fifo.sv
// ============================================================================
// ctls_fifo
// Output queue for token words; takes up to three words a cycle, gives one unless stalled.
// ============================================================================
module ctls_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  ctls_pkg::tok_push_t push,
    output logic                room,
    output logic                tok_valid,
    input  logic                tok_stall,
    output ctls_pkg::tok_word_t tok_word
);
    import ctls_pkg::*;

    tok_word_t             mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_reg, rd_reg;
    logic [FIFO_CNT_W-1:0] cnt_reg;
    logic                  pop;

    assign pop       = tok_valid && !tok_stall;
    assign tok_valid = cnt_reg != '0;
    assign tok_word  = mem[rd_reg];
    assign room      = cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH - 3);

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_reg + FIFO_PTR_W'(push.count);
            rd_reg  <= rd_reg + FIFO_PTR_W'(pop);
            cnt_reg <= cnt_reg + FIFO_CNT_W'(push.count) - FIFO_CNT_W'(pop);
        end
    end

    // Word storage.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (i < int'(push.count))
                mem[wr_reg + FIFO_PTR_W'(i)] <= push.words[i];
        end
    end

    // Pushes never overrun the queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("output queue overflow");

    // The fill count tracks pushes and pops.
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 cnt_reg == $past(cnt_reg) + FIFO_CNT_W'($past(push.count))
                       - FIFO_CNT_W'($past(pop)))
        else $error("output queue count mismatch");

endmodule
